[design/owdk_pkg.sv]
// Shared types, pipeline stage map and fixed-point constants for the omni-wheel drive block.
package owdk_pkg;

    localparam int unsigned NUM_WHEELS = 3;

    // Pipeline stage map. Every stage holds one item; the last one is the output register.
    localparam int unsigned LOG_FRAC_BITS = 16;
    localparam int unsigned ST_IN         = 0;
    localparam int unsigned ST_PROD       = 1;
    localparam int unsigned ST_SUM        = 2;
    localparam int unsigned ST_LZ         = 3;
    localparam int unsigned ST_NORM       = 4;
    localparam int unsigned ST_SQ0        = 5;
    localparam int unsigned ST_SQ_LAST    = ST_SQ0 + LOG_FRAC_BITS - 1;
    localparam int unsigned ST_LNMUL      = ST_SQ_LAST + 1;
    localparam int unsigned ST_LNABS      = ST_LNMUL + 1;
    localparam int unsigned ST_KMUL       = ST_LNABS + 1;
    localparam int unsigned ST_OUT        = ST_KMUL + 1;
    localparam int unsigned NUM_STAGES    = ST_OUT + 1;

    typedef logic [NUM_STAGES-1:0] stage_vec_t;

    typedef struct packed {
        logic signed [31:0] heading;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } pose_t;

    // Rim speed coefficients in Q16: -sin(a), cos(a) and the base radius 0.2.
    localparam logic signed [17:0] COEF_VX [NUM_WHEELS] = '{-18'sd32768, -18'sd32768, 18'sd65536};
    localparam logic signed [17:0] COEF_VY [NUM_WHEELS] = '{18'sd56756, -18'sd56756, 18'sd0};
    localparam logic signed [17:0] COEF_W  [NUM_WHEELS] = '{18'sd13107, 18'sd13107, 18'sd13107};

    // Drive calibration in Q16, per wheel and direction.
    localparam logic [22:0] FWD_K [NUM_WHEELS] = '{23'd5215459, 23'd7428009, 23'd6247212};
    localparam logic [25:0] FWD_C [NUM_WHEELS] = '{26'd25783532, 26'd38709940, 26'd19735229};
    localparam logic [22:0] REV_K [NUM_WHEELS] = '{23'd3093882, 23'd4848950, 23'd2556718};
    localparam logic [25:0] REV_C [NUM_WHEELS] = '{26'd13863917, 26'd25361344, 26'd11172383};

    // Natural log: ln2 in Q32 and the Q16 offset ln(45*pi/30) + 16*ln2.
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam logic [19:0] LN_OFFSET_Q16 = 20'd828411;

    // Wheel speed = round(|S| / 184320). 184320 = 4096 * 45: a shift, then a
    // reciprocal multiply by ceil(2^27 / 45), exact for quotients of 21-bit values.
    localparam logic [16:0] SPD_ROUND       = 17'd92160;
    localparam int unsigned SPD_SHIFT       = 12;
    localparam logic [21:0] SPD_RECIP       = 22'd2982617;
    localparam int unsigned SPD_RECIP_SHIFT = 27;

    localparam logic [15:0]        WS_POS_LIMIT = 16'd32767;
    localparam logic [15:0]        WS_NEG_LIMIT = 16'd32768;
    localparam logic signed [15:0] WS_MAX       = 16'sh7FFF;
    localparam logic signed [15:0] WS_MIN       = 16'sh8000;
    localparam logic [10:0]        PCT_LIMIT    = 11'd100;

endpackage

[design/omni_wheel_drive_kinematics.sv]
// Top level of the three-wheel omni drive kinematics pipeline with pose integration.
// Each command's result reaches the output register after passing every stage.
// One command per cycle unless the output stalls; the depth is set by the sixteen
// squaring stages of the fixed-point log2, one multiplier per stage in each of the three
// wheel lanes. Reset (rst_n low, asynchronous) empties the pipeline and clears the
// heading and position accumulators to zero.
module omni_wheel_drive_kinematics
(
    input  logic         clk,
    input  logic         rst_n,
    // Command channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // vel_x [15:0], vel_y [31:16], turn_rate [47:32]
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata    // wheel_speed_a [15:0], wheel_speed_b [31:16],
                                    // wheel_speed_c [47:32], drive_pct_a [55:48],
                                    // drive_pct_b [63:56], drive_pct_c [71:64],
                                    // heading_out [103:72], position_x_out [135:104],
                                    // position_y_out [167:136]
);

    localparam int unsigned NS = owdk_pkg::NUM_STAGES;

    owdk_pkg::stage_vec_t valid_reg;
    owdk_pkg::stage_vec_t stage_ready;
    logic signed [15:0]   vel_x_in;
    logic signed [15:0]   vel_y_in;
    logic signed [15:0]   turn_in;
    logic signed [15:0]   vel_x_reg;
    logic signed [15:0]   vel_y_reg;
    logic signed [15:0]   turn_reg;
    logic signed [15:0]   ws_arr  [owdk_pkg::NUM_WHEELS];
    logic signed [7:0]    pct_arr [owdk_pkg::NUM_WHEELS];
    owdk_pkg::pose_t      pose;

    assign vel_x_in = $signed(s_tdata[15:0]);
    assign vel_y_in = $signed(s_tdata[31:16]);
    assign turn_in  = $signed(s_tdata[47:32]);

    // Each stage can take a new item when it is empty or when its own item moves on.
    // Bubbles therefore close up, so commands keep being accepted while a finished
    // result waits at the output as long as the pipeline has a free slot.
    always_comb
    begin
        stage_ready[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    assign s_tready = stage_ready[owdk_pkg::ST_IN];
    assign m_tvalid = valid_reg[owdk_pkg::ST_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[owdk_pkg::ST_IN])
            begin
                valid_reg[owdk_pkg::ST_IN] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (stage_ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Input register; payload only, the valid flag above qualifies it.
    always_ff @(posedge clk)
    begin
        if (stage_ready[owdk_pkg::ST_IN])
        begin
            vel_x_reg <= vel_x_in;
            vel_y_reg <= vel_y_in;
            turn_reg  <= turn_in;
        end
    end

    // Wheel lanes: each computes its wheel speed and drive percentage in lock step
    // with the shared stage enables.
    for (genvar k = 0; k < owdk_pkg::NUM_WHEELS; k++)
    begin : g_wheel
        owdk_wheel
        #(
            .WHEEL (k)
        )
        u_wheel
        (
            .clk         (clk),
            .stage_en    (stage_ready),
            .vel_x       (vel_x_reg),
            .vel_y       (vel_y_reg),
            .turn_rate   (turn_reg),
            .wheel_speed (ws_arr[k]),
            .drive_pct   (pct_arr[k])
        );
    end

    // The pose is integrated once per accepted command, in order of arrival, and the
    // value after each command rides along with it to the output register.
    owdk_pose u_pose
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_tvalid && s_tready),
        .vel_x     (vel_x_in),
        .vel_y     (vel_y_in),
        .turn_rate (turn_in),
        .stage_en  (stage_ready),
        .pose      (pose)
    );

    assign m_tdata = {pose.pos_y, pose.pos_x, pose.heading,
                      pct_arr[2], pct_arr[1], pct_arr[0],
                      ws_arr[2], ws_arr[1], ws_arr[0]};

endmodule

[design/owdk_pose.sv]
// Saturating pose accumulators and the line that carries each item's pose to the output.
module owdk_pose
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic signed [15:0]  vel_x,
    input  logic signed [15:0]  vel_y,
    input  logic signed [15:0]  turn_rate,
    input  owdk_pkg::stage_vec_t stage_en,
    output owdk_pkg::pose_t     pose
);

    owdk_pkg::pose_t acc_reg;
    owdk_pkg::pose_t acc_next;
    owdk_pkg::pose_t pose_reg [owdk_pkg::ST_PROD:owdk_pkg::ST_OUT];

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                   input logic signed [15:0] delta);
        logic signed [32:0] sum;
        sum = 33'(acc) + 33'(delta);
        if (sum[32] != sum[31])
        begin
            return sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        end
        return sum[31:0];
    endfunction

    always_comb
    begin
        acc_next.heading = sat_add(acc_reg.heading, turn_rate);
        acc_next.pos_x   = sat_add(acc_reg.pos_x, vel_x);
        acc_next.pos_y   = sat_add(acc_reg.pos_y, vel_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
        end
    end

    // The accumulators hold the pose after the item in the input stage.
    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_PROD])
        begin
            pose_reg[owdk_pkg::ST_PROD] <= acc_reg;
        end
        for (int i = owdk_pkg::ST_PROD + 1; i <= owdk_pkg::ST_OUT; i++)
        begin
            if (stage_en[i])
            begin
                pose_reg[i] <= pose_reg[i-1];
            end
        end
    end

    assign pose = pose_reg[owdk_pkg::ST_OUT];

endmodule

[design/owdk_wheel.sv]
// One wheel lane: rim speed, rounded wheel speed, pipelined log and drive percentage.
module owdk_wheel
#(
    parameter int unsigned WHEEL = 0
)
(
    input  logic                 clk,
    input  owdk_pkg::stage_vec_t stage_en,
    input  logic signed [15:0]   vel_x,
    input  logic signed [15:0]   vel_y,
    input  logic signed [15:0]   turn_rate,
    output logic signed [15:0]   wheel_speed,
    output logic signed [7:0]    drive_pct
);

    localparam int unsigned SQL = owdk_pkg::ST_SQ_LAST;

    logic signed [33:0] prod_vx_reg;
    logic signed [33:0] prod_vy_reg;
    logic signed [33:0] prod_w_reg;
    logic signed [34:0] rim_sum;
    logic [31:0]        mag_reg  [owdk_pkg::ST_SUM:owdk_pkg::ST_LZ];
    logic               neg_reg  [owdk_pkg::ST_SUM:owdk_pkg::ST_KMUL];
    logic               nz_reg   [owdk_pkg::ST_SUM:owdk_pkg::ST_KMUL];
    logic [4:0]         lead_next;
    logic [4:0]         lead_reg [owdk_pkg::ST_LZ:SQL];
    logic [32:0]        spd_round;
    logic [20:0]        spd_div_reg;
    logic [42:0]        spd_prod_reg;
    logic [15:0]        spd_q;
    logic signed [16:0] spd_neg;
    logic signed [15:0] ws_next;
    logic signed [15:0] ws_reg   [owdk_pkg::ST_SQ0:owdk_pkg::ST_OUT];
    logic [30:0]        mant_next;
    logic [30:0]        mant_reg [owdk_pkg::ST_NORM:SQL];
    logic [15:0]        frac_reg [owdk_pkg::ST_SQ0:SQL];
    logic [52:0]        ln_prod_reg;
    logic [21:0]        ln_round;
    logic signed [22:0] ln_diff;
    logic [19:0]        ln_abs_reg;
    logic [42:0]        kla_reg;
    logic [25:0]        cal_c;
    logic signed [44:0] pct_raw;
    logic [6:0]         pct_mag;
    logic signed [7:0]  pct_next;
    logic signed [7:0]  pct_reg;

    // Rim speed in Q16 mm/s.
    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_PROD])
        begin
            prod_vx_reg <= owdk_pkg::COEF_VX[WHEEL] * vel_x;
            prod_vy_reg <= owdk_pkg::COEF_VY[WHEEL] * vel_y;
            prod_w_reg  <= owdk_pkg::COEF_W[WHEEL] * turn_rate;
        end
    end

    assign rim_sum = prod_vx_reg + prod_vy_reg + prod_w_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_SUM])
        begin
            mag_reg[owdk_pkg::ST_SUM] <= rim_sum[34] ? 32'(-rim_sum) : 32'(rim_sum);
        end
    end

    // Leading one of the magnitude and the rounded, pre-shifted speed dividend.
    always_comb
    begin
        lead_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag_reg[owdk_pkg::ST_SUM][i])
            begin
                lead_next = 5'(i);
            end
        end
    end

    assign spd_round = 33'(mag_reg[owdk_pkg::ST_SUM]) + 33'(owdk_pkg::SPD_ROUND);

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_LZ])
        begin
            mag_reg[owdk_pkg::ST_LZ]     <= mag_reg[owdk_pkg::ST_SUM];
            spd_div_reg                  <= spd_round[owdk_pkg::SPD_SHIFT +: 21];
        end
    end

    // Normalize the mantissa to Q30 and form the reciprocal product.
    always_comb
    begin
        if (lead_reg[owdk_pkg::ST_LZ] == 5'd31)
        begin
            mant_next = mag_reg[owdk_pkg::ST_LZ][31:1];
        end
        else
        begin
            mant_next = 31'(mag_reg[owdk_pkg::ST_LZ] << (5'd30 - lead_reg[owdk_pkg::ST_LZ]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_NORM])
        begin
            mant_reg[owdk_pkg::ST_NORM] <= mant_next;
            spd_prod_reg                <= spd_div_reg * owdk_pkg::SPD_RECIP;
        end
    end

    // Signed, saturated wheel speed.
    assign spd_q   = spd_prod_reg[owdk_pkg::SPD_RECIP_SHIFT +: 16];
    assign spd_neg = -$signed({1'b0, spd_q});

    always_comb
    begin
        if (neg_reg[owdk_pkg::ST_NORM])
        begin
            ws_next = (spd_q > owdk_pkg::WS_NEG_LIMIT) ? owdk_pkg::WS_MIN : spd_neg[15:0];
        end
        else
        begin
            ws_next = (spd_q > owdk_pkg::WS_POS_LIMIT) ? owdk_pkg::WS_MAX : $signed(spd_q);
        end
    end

    // One fraction bit of log2 per stage by squaring the mantissa.
    for (genvar j = 0; j < owdk_pkg::LOG_FRAC_BITS; j++)
    begin : g_sq
        localparam int unsigned S = owdk_pkg::ST_SQ0 + j;
        logic [61:0] sq;
        logic [31:0] sq_top;

        assign sq     = mant_reg[S-1] * mant_reg[S-1];
        assign sq_top = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (stage_en[S])
            begin
                mant_reg[S] <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
            end
        end

        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (stage_en[S])
                begin
                    frac_reg[S] <= 16'(sq_top[31]);
                end
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (stage_en[S])
                begin
                    frac_reg[S] <= {frac_reg[S-1][14:0], sq_top[31]};
                end
            end
        end
    end

    // Side-band lines that travel with the item.
    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_SUM])
        begin
            neg_reg[owdk_pkg::ST_SUM] <= rim_sum[34];
            nz_reg[owdk_pkg::ST_SUM]  <= (rim_sum != '0);
        end
        for (int i = owdk_pkg::ST_SUM + 1; i <= owdk_pkg::ST_KMUL; i++)
        begin
            if (stage_en[i])
            begin
                neg_reg[i] <= neg_reg[i-1];
                nz_reg[i]  <= nz_reg[i-1];
            end
        end
        if (stage_en[owdk_pkg::ST_LZ])
        begin
            lead_reg[owdk_pkg::ST_LZ] <= lead_next;
        end
        for (int i = owdk_pkg::ST_LZ + 1; i <= SQL; i++)
        begin
            if (stage_en[i])
            begin
                lead_reg[i] <= lead_reg[i-1];
            end
        end
        if (stage_en[owdk_pkg::ST_SQ0])
        begin
            ws_reg[owdk_pkg::ST_SQ0] <= ws_next;
        end
        for (int i = owdk_pkg::ST_SQ0 + 1; i <= owdk_pkg::ST_OUT; i++)
        begin
            if (stage_en[i])
            begin
                ws_reg[i] <= ws_reg[i-1];
            end
        end
    end

    // ln = round(ln2 * log2) - offset, then its magnitude.
    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_LNMUL])
        begin
            ln_prod_reg <= {lead_reg[SQL], frac_reg[SQL]} * owdk_pkg::LN2_Q32;
        end
    end

    assign ln_round = 22'(ln_prod_reg[52:32]) + 22'(ln_prod_reg[31]);
    assign ln_diff  = $signed({1'b0, ln_round}) - $signed({3'b0, owdk_pkg::LN_OFFSET_Q16});

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_LNABS])
        begin
            ln_abs_reg <= ln_diff[22] ? 20'(-ln_diff) : 20'(ln_diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_KMUL])
        begin
            kla_reg <= (neg_reg[owdk_pkg::ST_LNABS] ? owdk_pkg::REV_K[WHEEL]
                                                     : owdk_pkg::FWD_K[WHEEL]) * ln_abs_reg;
        end
    end

    // Both directions reduce to k*|ln| - c; reverse takes the negated magnitude.
    assign cal_c   = neg_reg[owdk_pkg::ST_KMUL] ? owdk_pkg::REV_C[WHEEL] : owdk_pkg::FWD_C[WHEEL];
    assign pct_raw = $signed({2'b0, kla_reg}) - $signed({3'b0, cal_c, 16'b0});

    always_comb
    begin
        if (pct_raw[44])
        begin
            pct_mag = '0;
        end
        else if (pct_raw[42:32] > owdk_pkg::PCT_LIMIT)
        begin
            pct_mag = 7'(owdk_pkg::PCT_LIMIT);
        end
        else
        begin
            pct_mag = pct_raw[38:32];
        end

        if (!nz_reg[owdk_pkg::ST_KMUL])
        begin
            pct_next = '0;
        end
        else if (neg_reg[owdk_pkg::ST_KMUL])
        begin
            pct_next = -$signed({1'b0, pct_mag});
        end
        else
        begin
            pct_next = $signed({1'b0, pct_mag});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[owdk_pkg::ST_OUT])
        begin
            pct_reg <= pct_next;
        end
    end

    assign wheel_speed = ws_reg[owdk_pkg::ST_OUT];
    assign drive_pct   = pct_reg;

endmodule

[design/owdk_checker.sv]
// Port-level checks for the omni-wheel drive block, bound to its top level.
module owdk_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    logic signed [15:0] ws_a;
    logic signed [15:0] ws_b;
    logic signed [15:0] ws_c;
    logic signed [7:0]  pct_a;
    logic signed [7:0]  pct_b;
    logic signed [7:0]  pct_c;
    logic               pct_in_range;
    logic               pct_sign_ok;
    logic               in_seen;

    assign ws_a  = $signed(m_tdata[15:0]);
    assign ws_b  = $signed(m_tdata[31:16]);
    assign ws_c  = $signed(m_tdata[47:32]);
    assign pct_a = $signed(m_tdata[55:48]);
    assign pct_b = $signed(m_tdata[63:56]);
    assign pct_c = $signed(m_tdata[71:64]);

    assign pct_in_range = (pct_a <= 8'sd100) && (pct_a >= -8'sd100) &&
                          (pct_b <= 8'sd100) && (pct_b >= -8'sd100) &&
                          (pct_c <= 8'sd100) && (pct_c >= -8'sd100);

    // A wheel that turns one way is never driven the other way.
    assign pct_sign_ok = !((ws_a > 0) && (pct_a < 0)) && !((ws_a < 0) && (pct_a > 0)) &&
                         !((ws_b > 0) && (pct_b < 0)) && !((ws_b < 0) && (pct_b > 0)) &&
                         !((ws_c > 0) && (pct_c < 0)) && !((ws_c < 0) && (pct_c > 0));

    // Sticky flag: some command transfer has happened since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seen <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_seen <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pct_in_range)
        else $error("drive percentage outside -100..100");

    a_pct_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pct_sign_ok)
        else $error("drive percentage sign disagrees with wheel speed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> in_seen)
        else $error("result shown before any command transfer");

endmodule

bind omni_wheel_drive_kinematics owdk_checker u_owdk_checker (.*);
